### design/rcd_pkg.sv
// Package for the RIFF chunk deframer: beat types, tags and codes.
package rcd_pkg;

  localparam int POS_BITS = 32;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_LIST = 32'h4C49_5354;

  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_LIST  = 2'd1;
  localparam logic [1:0] KIND_RIFF  = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_CORRUPT = 1'b1;

  localparam logic [1:0] HDR_LAST = 2'd3;
  localparam logic [31:0] LIST_HDR_BYTES = 32'd4;

  typedef enum logic [4:0] {
    PH_ID       = 5'b00001,
    PH_SIZE     = 5'b00010,
    PH_SUB_LIST = 5'b00100,
    PH_SUB_RIFF = 5'b01000,
    PH_SKIP     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       body_start;
  } in_beat_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  chunk_kind;
    logic [31:0] chunk_id;
    logic [31:0] payload_size;
    logic [31:0] payload_offset;
    logic        ends_body;
  } out_beat_t;

endpackage

### design/riff_chunk_deframer.sv
// RIFF chunk deframer top level: header parse, skip counter and result register.
// A record is registered and appears on out_valid in the cycle after the beat that completes its header.
// Throughput: one input beat per cycle while in_stall is low; the combinational parse path sets this rate.
// in_stall is high only while the result register holds a record and out_stall is high.
// Reset (rst, synchronous) clears the parse state, body_length and out_valid.
module riff_chunk_deframer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rcd_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rcd_pkg::out_beat_t out_data,
  input  logic              cfg_write_en,
  input  logic [31:0]       cfg_write_data
);
  import rcd_pkg::*;

  logic [31:0]         body_length;
  phase_t              phase, phase_next;
  logic [1:0]          hdr_count, hdr_count_next;
  logic [31:0]         id_shift, id_shift_next;
  logic [31:0]         size_shift, size_shift_next;
  logic [32:0]         skip_remaining, skip_remaining_next;
  logic [POS_BITS-1:0] body_position, body_position_next;
  logic                error_latched, error_latched_next;
  logic                out_valid_next;
  out_beat_t           out_data_next;

  logic                accept;
  logic                produce;
  out_beat_t           res;
  logic [POS_BITS-1:0] blen;
  logic [POS_BITS-1:0] pos_inc;
  logic                last;
  logic                complete;
  logic                fin;
  logic [1:0]          fin_kind;
  logic [31:0]         psize;
  logic                pad;
  logic [32:0]         end_pos;
  logic                bad;
  logic [32:0]         skip_dec;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign blen     = body_length[POS_BITS-1:0];

  always_comb begin
    phase_next          = phase;
    hdr_count_next      = hdr_count;
    id_shift_next       = id_shift;
    size_shift_next     = size_shift;
    skip_remaining_next = skip_remaining;
    body_position_next  = body_position;
    error_latched_next  = error_latched;
    produce             = 1'b0;
    res                 = '0;
    fin                 = 1'b0;
    fin_kind            = KIND_PLAIN;
    psize               = '0;
    pad                 = 1'b0;
    end_pos             = '0;
    bad                 = 1'b0;
    skip_dec            = skip_remaining - 33'd1;
    complete            = 1'b0;

    if (in_data.body_start) begin
      phase_next          = PH_ID;
      hdr_count_next      = '0;
      id_shift_next       = '0;
      size_shift_next     = '0;
      skip_remaining_next = '0;
      body_position_next  = '0;
      error_latched_next  = 1'b0;
    end

    pos_inc  = body_position_next + POS_BITS'(1);
    last     = (pos_inc == blen);
    skip_dec = skip_remaining_next - 33'd1;

    if (!error_latched_next && (body_position_next < blen)) begin
      body_position_next = pos_inc;
      if (phase_next == PH_SKIP) begin
        skip_remaining_next = skip_dec;
        if (skip_dec == '0) begin
          phase_next = PH_ID;
        end
      end else begin
        complete       = (hdr_count_next == HDR_LAST);
        hdr_count_next = hdr_count_next + 2'd1;
        if (phase_next == PH_SIZE) begin
          size_shift_next = {in_data.data_byte, size_shift_next[31:8]};
          if (complete) begin
            if (id_shift_next == TAG_LIST) begin
              phase_next = PH_SUB_LIST;
            end else if (id_shift_next == TAG_RIFF) begin
              phase_next = PH_SUB_RIFF;
            end else begin
              fin      = 1'b1;
              fin_kind = KIND_PLAIN;
            end
          end
        end else begin
          id_shift_next = {id_shift_next[23:0], in_data.data_byte};
          if (complete) begin
            case (phase_next)
              PH_SUB_LIST: begin
                fin      = 1'b1;
                fin_kind = KIND_LIST;
              end
              PH_SUB_RIFF: begin
                fin      = 1'b1;
                fin_kind = KIND_RIFF;
              end
              default: begin
                phase_next = PH_SIZE;
              end
            endcase
          end
        end

        if (fin) begin
          pad   = size_shift_next[0];
          psize = (fin_kind == KIND_PLAIN) ? size_shift_next
                                           : size_shift_next - LIST_HDR_BYTES;
          end_pos = 33'(pos_inc) + {1'b0, psize} + 33'(pad);
          bad = ((fin_kind != KIND_PLAIN) && (size_shift_next < LIST_HDR_BYTES)) ||
                (end_pos > 33'(blen));
          produce            = 1'b1;
          res.status         = bad ? STATUS_CORRUPT : STATUS_OK;
          res.chunk_kind     = fin_kind;
          res.chunk_id       = id_shift_next;
          res.payload_size   = psize;
          res.payload_offset = 32'(pos_inc);
          res.ends_body      = ~bad & (end_pos == 33'(blen));
          if (bad) begin
            error_latched_next = 1'b1;
          end else begin
            skip_remaining_next = {1'b0, psize} + 33'(pad);
            phase_next = (skip_remaining_next != '0) ? PH_SKIP : PH_ID;
          end
        end else if (last) begin
          produce            = 1'b1;
          res                = '0;
          res.status         = STATUS_CORRUPT;
          error_latched_next = 1'b1;
        end
      end
    end
  end

  assign out_valid_next = (accept & produce) | (out_valid & out_stall);
  assign out_data_next  = (accept & produce) ? res : out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_length    <= '0;
      phase          <= PH_ID;
      hdr_count      <= '0;
      id_shift       <= '0;
      size_shift     <= '0;
      skip_remaining <= '0;
      body_position  <= '0;
      error_latched  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        body_length <= cfg_write_data;
      end
      if (accept) begin
        phase          <= phase_next;
        hdr_count      <= hdr_count_next;
        id_shift       <= id_shift_next;
        size_shift     <= size_shift_next;
        skip_remaining <= skip_remaining_next;
        body_position  <= body_position_next;
        error_latched  <= error_latched_next;
      end
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_data_next;
  end

  // skip phase always has bytes left to drop
  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> skip_remaining != '0)
    else $error("skip phase with zero count");

  // latched error swallows bytes until a body start
  a_err_silent: assert property (@(posedge clk) disable iff (rst)
    accept && error_latched && !in_data.body_start |-> !produce)
    else $error("record produced while error latched");

  a_corrupt_latches: assert property (@(posedge clk) disable iff (rst)
    accept && produce && res.status == STATUS_CORRUPT |=> error_latched)
    else $error("corrupt record did not latch error");

  a_ok_next_phase: assert property (@(posedge clk) disable iff (rst)
    accept && produce && res.status == STATUS_OK |=>
      (phase == PH_SKIP) || (phase == PH_ID))
    else $error("good record left parser mid header");

  a_record_loaded: assert property (@(posedge clk) disable iff (rst)
    accept && produce |=> out_valid && out_data == $past(res))
    else $error("record not loaded into result register");

endmodule

### tb/tb_riff_chunk_deframer.sv
// Testbench for riff_chunk_deframer: directed and random byte streams of RIFF bodies checked against a predictor.
module tb_riff_chunk_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import rcd_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS = 10;
  localparam int LONG_HOLD = 200;
  localparam logic [31:0] POS_MASK = 32'hFFFF_FFFF >> (32 - POS_BITS);

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_beat_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_beat_t  out_data;
  logic        cfg_write_en = 1'b0;
  logic [31:0] cfg_write_data = '0;

  riff_chunk_deframer i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  in_beat_t  byte_q[$];
  out_beat_t record_q[$];
  int queued_total = 0;
  int accepted_total = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int tx_gap = 0, tx_quiet = 0;
  int rx_hold = 0, rx_quiet = 0;
  bit next_start = 1'b0;

  // parser state mirror
  logic [31:0] body_len_cfg;
  phase_t      ph;
  logic [1:0]  hdr_cnt;
  logic [31:0] id_sr, size_sr, body_pos;
  logic [32:0] skip_left;
  bit          err_latched;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic restart_parse();
    ph = PH_ID;
    hdr_cnt = '0;
    id_sr = '0;
    size_sr = '0;
    skip_left = '0;
    body_pos = '0;
    err_latched = 1'b0;
  endtask

  task automatic close_header(logic [1:0] kind, logic [31:0] at, logic [31:0] lim);
    logic [31:0] psz, off;
    logic        pad, bad;
    logic [33:0] stop;
    out_beat_t   r;
    pad = size_sr[0];
    psz = size_sr;
    bad = 1'b0;
    off = at + 32'd1;
    if (kind != KIND_PLAIN) begin
      if (size_sr < LIST_HDR_BYTES) bad = 1'b1;
      psz = size_sr - LIST_HDR_BYTES;
    end
    stop = {2'b0, off} + {2'b0, psz} + {33'b0, pad};
    if (stop > {2'b0, lim}) bad = 1'b1;
    r.status = bad ? STATUS_CORRUPT : STATUS_OK;
    r.chunk_kind = kind;
    r.chunk_id = id_sr;
    r.payload_size = psz;
    r.payload_offset = off;
    r.ends_body = !bad && (stop == {2'b0, lim});
    record_q.push_back(r);
    if (bad) begin
      err_latched = 1'b1;
    end else begin
      skip_left = {1'b0, psz} + {32'b0, pad};
      ph = (skip_left != '0) ? PH_SKIP : PH_ID;
    end
  endtask

  task automatic predict_beat(in_beat_t b);
    logic [31:0] lim, at;
    logic        last_byte, hdr_done;
    out_beat_t   r;
    lim = body_len_cfg & POS_MASK;
    if (b.body_start) restart_parse();
    if (err_latched || body_pos >= lim) return;
    at = body_pos;
    last_byte = (at + 32'd1 == lim);
    body_pos = at + 32'd1;
    if (ph == PH_SKIP) begin
      if (skip_left != '0) skip_left = skip_left - 33'd1;
      if (skip_left == '0) ph = PH_ID;
      return;
    end
    hdr_done = (hdr_cnt == HDR_LAST);
    hdr_cnt = hdr_cnt + 2'd1;
    if (ph == PH_SIZE) begin
      size_sr = {b.data_byte, size_sr[31:8]};
      if (hdr_done) begin
        if (id_sr == TAG_LIST) ph = PH_SUB_LIST;
        else if (id_sr == TAG_RIFF) ph = PH_SUB_RIFF;
        else begin
          close_header(KIND_PLAIN, at, lim);
          return;
        end
      end
    end else begin
      id_sr = {id_sr[23:0], b.data_byte};
      if (hdr_done) begin
        if (ph == PH_SUB_LIST) begin
          close_header(KIND_LIST, at, lim);
          return;
        end
        if (ph == PH_SUB_RIFF) begin
          close_header(KIND_RIFF, at, lim);
          return;
        end
        ph = PH_SIZE;
      end
    end
    // header cut short by the end of the body
    if (last_byte) begin
      r = '0;
      r.status = STATUS_CORRUPT;
      record_q.push_back(r);
      err_latched = 1'b1;
    end
  endtask

  task automatic check_record(out_beat_t got);
    out_beat_t want;
    if (record_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected record: st=%0d kind=%0d id=%h size=%h off=%h end=%0d",
                 got.status, got.chunk_kind, got.chunk_id, got.payload_size,
                 got.payload_offset, got.ends_body);
      return;
    end
    want = record_q.pop_front();
    if (got.status != want.status || got.chunk_kind != want.chunk_kind ||
        got.chunk_id != want.chunk_id || got.payload_size != want.payload_size ||
        got.payload_offset != want.payload_offset || got.ends_body != want.ends_body) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("record: exp st=%0d kind=%0d id=%h size=%h off=%h end=%0d / got st=%0d kind=%0d id=%h size=%h off=%h end=%0d",
                 want.status, want.chunk_kind, want.chunk_id, want.payload_size,
                 want.payload_offset, want.ends_body,
                 got.status, got.chunk_kind, got.chunk_id, got.payload_size,
                 got.payload_offset, got.ends_body);
    end
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_beat(in_data);
        accepted_total++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          in_data <= byte_q.pop_front();
          in_valid <= 1'b1;
          if (tx_quiet > 0) begin
            tx_quiet--;
          end else begin
            tx_gap = idle_len();
            if ($urandom_range(0, 39) == 0) tx_quiet = $urandom_range(20, 80);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // record monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_record(out_data);
      if (holds_done < hold_requests) begin
        holds_done++;
        rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (rx_quiet > 0) begin
          rx_quiet--;
        end else begin
          rx_hold = ($urandom_range(0, 2) == 0) ? idle_len() : 0;
          if ($urandom_range(0, 39) == 0) rx_quiet = $urandom_range(20, 80);
        end
      end
    end
  end

  task automatic push_beat(logic [7:0] d);
    in_beat_t b;
    b.data_byte = d;
    b.body_start = next_start;
    next_start = 1'b0;
    byte_q.push_back(b);
    queued_total++;
  endtask

  task automatic push_noise(int n);
    for (int i = 0; i < n; i++) push_beat(8'($urandom_range(0, 255)));
  endtask

  task automatic push_be(logic [31:0] v);
    push_beat(v[31:24]);
    push_beat(v[23:16]);
    push_beat(v[15:8]);
    push_beat(v[7:0]);
  endtask

  task automatic push_le(logic [31:0] v);
    push_beat(v[7:0]);
    push_beat(v[15:8]);
    push_beat(v[23:16]);
    push_beat(v[31:24]);
  endtask

  task automatic push_header(logic [1:0] kind, logic [31:0] id, logic [31:0] sz);
    if (kind == KIND_PLAIN) begin
      push_be(id);
      push_le(sz);
    end else begin
      push_be(kind == KIND_LIST ? TAG_LIST : TAG_RIFF);
      push_le(sz);
      push_be(id);
    end
  endtask

  function automatic logic [1:0] pick_kind(longint rem);
    int r;
    r = $urandom_range(0, 3);
    if (rem < 12 || r < 2) return KIND_PLAIN;
    return (r == 2) ? KIND_LIST : KIND_RIFF;
  endfunction

  function automatic logic [31:0] pick_id(logic [1:0] kind);
    logic [31:0] id;
    id = $urandom;
    if (kind == KIND_PLAIN && (id == TAG_LIST || id == TAG_RIFF)) id[0] = ~id[0];
    return id;
  endfunction

  task automatic push_good_chunk(longint rem, output longint used);
    logic [1:0] kind;
    longint     hdr, room, p;
    bit         huge;
    kind = pick_kind(rem);
    hdr = (kind == KIND_PLAIN) ? 8 : 12;
    room = rem - hdr;
    huge = 1'b0;
    if (room > 4096 && $urandom_range(0, 3) == 0) begin
      p = room[0] ? room - 1 : room;
      huge = 1'b1;
    end else if (room <= 4096 && $urandom_range(0, 4) == 0) begin
      // fill the body up to its end, or to one byte short of it when the room left is odd
      if (room[0]) p = room - 1;
      else if (room > 0 && $urandom_range(0, 1) == 1) p = room - 1;
      else p = room;
    end else begin
      p = $urandom_range(0, (room < 24) ? int'(room) : 24);
      if (p[0] && p + 1 > room) p = p - 1;
    end
    push_header(kind, pick_id(kind), 32'((kind == KIND_PLAIN) ? p : p + 4));
    if (huge) begin
      push_noise(3);
      used = rem;
    end else begin
      push_noise(int'(p + p[0]));
      used = hdr + p + p[0];
    end
  endtask

  task automatic push_bad_chunk(longint rem);
    logic [1:0]  kind;
    longint      room, p;
    logic [31:0] sz;
    kind = pick_kind(rem);
    room = rem - ((kind == KIND_PLAIN) ? 8 : 12);
    if (kind != KIND_PLAIN && $urandom_range(0, 1) == 1) begin
      sz = $urandom_range(0, 3);
    end else begin
      case ($urandom_range(0, 2))
        0: p = room + 1;
        1: p = room[0] ? room : room + 1;
        default: p = 64'h8000_0000 + $urandom_range(0, 32'h7FFF_FFFF);
      endcase
      sz = 32'((kind == KIND_PLAIN) ? p : p + 4);
    end
    push_header(kind, pick_id(kind), sz);
  endtask

  task automatic gen_body(longint lim);
    longint rem, used;
    int     mode, chunks;
    next_start = 1'b1;
    rem = lim;
    mode = $urandom_range(0, 9);
    chunks = 0;
    if (mode == 9) begin
      push_noise((rem > 0 && rem < 24) ? int'(rem) : $urandom_range(1, 24));
      return;
    end
    while (rem >= 8 && chunks < 8) begin
      if (mode == 8 && $urandom_range(0, 3) == 0) begin
        push_noise($urandom_range(1, 7));
        return;
      end
      if (mode == 7 && $urandom_range(0, 2) == 0) begin
        push_bad_chunk(rem);
        push_noise($urandom_range(0, 2));
        return;
      end
      push_good_chunk(rem, used);
      rem -= used;
      chunks++;
    end
    if (mode == 7 && rem >= 8) begin
      push_bad_chunk(rem);
      push_noise($urandom_range(0, 2));
      return;
    end
    if (rem < 8) push_noise(int'(rem));
    if (lim == 0 || $urandom_range(0, 3) == 0) push_noise($urandom_range(1, 2));
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (accepted_total != queued_total || record_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_body_length(logic [31:0] v);
    wait_idle();
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    body_len_cfg = v;
  endtask

  task automatic run_lengths(logic [31:0] len, int budget, bit with_hold);
    int target;
    set_body_length(len);
    @(negedge clk);
    if (with_hold) hold_requests++;
    target = queued_total + budget;
    while (queued_total < target) gen_body(longint'(len));
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("riff_chunk_deframer: mismatch");
    $finish;
  end

  initial begin
    body_len_cfg = '0;
    restart_parse();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: zero-size chunk, truncated header, byte past end, short LIST
    set_body_length(32'd12);
    next_start = 1'b1;
    push_header(KIND_PLAIN, 32'hFF00_807F, 32'd0);
    push_be(TAG_LIST);
    push_beat(8'h5A);
    next_start = 1'b1;
    push_header(KIND_LIST, 32'hFFFF_FFFF, 32'd2);

    run_lengths(32'd1, 40, 1'b0);
    run_lengths(32'd7, 60, 1'b0);
    run_lengths(32'd8, 60, 1'b0);
    run_lengths(32'd13, 60, 1'b0);
    run_lengths(32'd40, 60, 1'b0);
    run_lengths(32'd64, 60, 1'b0);
    run_lengths(32'd100, 60, 1'b0);
    run_lengths(32'd255, 120, 1'b1);
    run_lengths(32'd300, 60, 1'b0);
    for (int i = 0; i < 2; i++) run_lengths($urandom_range(20, 400), 40, 1'b0);
    run_lengths(32'hFFFF_FFFF, 60, 1'b0);
    run_lengths(32'h8000_0000, 40, 1'b0);
    run_lengths(32'd0, 8, 1'b0);

    wait_idle();
    if (mismatches == 0 && record_q.size() == 0) begin
      $display("riff_chunk_deframer: match");
    end else begin
      $display("riff_chunk_deframer: mismatch");
    end
    $finish;
  end

endmodule

### files.f
design/rcd_pkg.sv
design/riff_chunk_deframer.sv
tb/tb_riff_chunk_deframer.sv
